[src/cdq_pkg.sv]
package cdq_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int POS_W     = 7;
  localparam int POS2_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int DEPTH_DEF = 64;
  localparam int CMD_IDX_W = 10;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;
  localparam int TREE_RADIX = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_PEEK_FRONT = 4'd4,
    OP_PEEK_BACK  = 4'd5,
    OP_READ       = 4'd6,
    OP_WRITE      = 4'd7,
    OP_INSERT     = 4'd8,
    OP_REMOVE     = 4'd9,
    OP_SWAP       = 4'd10,
    OP_TRUNCATE   = 4'd11
  } cdq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } cdq_status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_SWAP,
    CMD_INSERT,
    CMD_DELETE
  } cdq_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_COMMIT,
    S_OUT
  } cdq_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [POS2_W-1:0] other_position;
    logic [DATA_W-1:0] data_in;
  } cdq_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]    data_out;
    cdq_status_e          status;
    logic [CNT_OUT_W-1:0] count;
  } cdq_out_t;

  // update broadcast to every cell in the commit cycle
  typedef struct packed {
    cdq_cmd_e             kind;
    logic [CMD_IDX_W-1:0] idx_a;
    logic [CMD_IDX_W-1:0] idx_b;
    logic [DATA_W-1:0]    data_a;
    logic [DATA_W-1:0]    data_b;
  } cdq_cmd_t;

  // number of radix-8 OR levels needed to reduce n leaves to one
  function automatic int cdq_tree_levels(int n);
    int lv;
    int span;
    lv = 1;
    span = TREE_RADIX;
    for (int i = 0; i < 12; i++) begin
      if (span < n) begin
        lv = lv + 1;
        span = span * TREE_RADIX;
      end
    end
    return lv;
  endfunction

endpackage

[src/circular_deque_engine_unit.sv]
// Bounded double-ended queue of 32-bit words, one word per cell of a chain.
// Input channel: in_valid_i / in_stall_o with an op word (op, position,
// other_position, data_in). Output channel: out_valid_o / out_stall_i with a
// result word (data_out, status, count). Every op word yields one result.
// Cells hold entries in logical order; insert and remove shift the chain by
// one cell in a single commit, so every op updates the cells at most once.
// Reads go through a registered radix-8 OR tree of L = ceil(log8(DEPTH))
// levels (L = 2 for 64 cells); each read waits until the root holds the word.
// Ops go from accept through S_COMMIT to S_OUT; push, write, insert,
// truncate and failed ops skip the tree, pop, peek, read and remove read one
// word through it, and swap reads two (S_READ_A, then S_READ_B).
// One word is in flight at a time, so a new word is taken only after the
// previous result has been handed off and in_stall_o has dropped.
// in_stall_o is high from accept until the result is taken; a result held
// by out_stall_i stays valid and unchanged.
// Reset empties the queue and sets capacity to DEPTH; no clearing pass.
// APB capacity (read at address 0, written at any address) clamps to 1..DEPTH; a write also empties the queue.
module circular_deque_engine_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdq_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdq_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LEVELS = cdq_tree_levels(DEPTH);
  localparam int WAIT_W = $clog2(LEVELS + 1);

  cdq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_nx;
  logic [CNT_W-1:0]  cap_q;
  cdq_in_t           req_q;
  cdq_status_e       stat_q, dec_status;
  logic [IDX_W-1:0]  rd_idx_q, dec_rd;
  logic [WAIT_W-1:0] wait_q;
  logic [DATA_W-1:0] word_a_q, word_b_q, dout_nx, root;
  cdq_out_t          out_q;
  cdq_cmd_t          cmd;
  logic              in_acc, cfg_wr, dec_read, full, empty;
  logic [CMP_W-1:0]  pos_ext, pos2_ext, cnt_ext;

  logic [DATA_W-1:0] cell_q [DEPTH];
  logic [DATA_W-1:0] tap    [DEPTH];

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;
  assign prdata      = (paddr == '0) ? PDATA_W'(cap_q) : '0;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  // ---------------- request decode against the current count
  assign pos_ext  = CMP_W'(in_data_i.position);
  assign pos2_ext = CMP_W'(in_data_i.other_position);
  assign cnt_ext  = CMP_W'(count_q);
  assign full     = (count_q >= cap_q);
  assign empty    = (count_q == '0);

  always_comb begin
    dec_status = ST_OK;
    dec_rd     = '0;
    case (cdq_op_e'(in_data_i.op))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) dec_status = ST_FULL;
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) dec_status = ST_EMPTY;
        dec_rd = IDX_W'(count_q - CNT_W'(1));
      end
      OP_READ, OP_WRITE, OP_REMOVE: begin
        if (pos_ext >= cnt_ext) dec_status = ST_RANGE;
        dec_rd = IDX_W'(in_data_i.position);
      end
      OP_INSERT: begin
        if (pos_ext > cnt_ext) dec_status = ST_RANGE;
        else if (full) dec_status = ST_FULL;
      end
      OP_SWAP: begin
        if (pos_ext >= cnt_ext || pos2_ext >= cnt_ext) dec_status = ST_RANGE;
        dec_rd = IDX_W'(in_data_i.position);
      end
      OP_TRUNCATE: begin
        if (pos_ext > cnt_ext) dec_status = ST_RANGE;
      end
      default: dec_status = ST_OK;
    endcase
  end

  assign dec_read = (dec_status == ST_OK) &&
                    (in_data_i.op inside {OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT,
                                          OP_PEEK_BACK, OP_READ, OP_REMOVE, OP_SWAP});

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = dec_read ? S_READ_A : S_COMMIT;
      end
      S_READ_A: begin
        if (wait_q == '0) state_d = (req_q.op == OP_SWAP) ? S_READ_B : S_COMMIT;
      end
      S_READ_B: begin
        if (wait_q == '0) state_d = S_COMMIT;
      end
      S_COMMIT: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- commit: cell update, new count, result word
  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NONE;
    cmd.data_a = req_q.data_in;
    cmd.data_b = word_a_q;
    count_nx   = count_q;
    dout_nx    = '0;
    if (state_q == S_COMMIT && stat_q == ST_OK) begin
      case (cdq_op_e'(req_q.op))
        OP_PUSH_FRONT: begin
          cmd.kind = CMD_INSERT;
          count_nx = count_q + CNT_W'(1);
        end
        OP_PUSH_BACK: begin
          cmd.kind  = CMD_WRITE;
          cmd.idx_a = CMD_IDX_W'(count_q);
          count_nx  = count_q + CNT_W'(1);
        end
        OP_POP_FRONT: begin
          cmd.kind = CMD_DELETE;
          count_nx = count_q - CNT_W'(1);
          dout_nx  = word_a_q;
        end
        OP_POP_BACK: begin
          count_nx = count_q - CNT_W'(1);
          dout_nx  = word_a_q;
        end
        OP_PEEK_FRONT, OP_PEEK_BACK, OP_READ: dout_nx = word_a_q;
        OP_WRITE: begin
          cmd.kind  = CMD_WRITE;
          cmd.idx_a = CMD_IDX_W'(req_q.position);
        end
        OP_INSERT: begin
          cmd.kind  = CMD_INSERT;
          cmd.idx_a = CMD_IDX_W'(req_q.position);
          count_nx  = count_q + CNT_W'(1);
        end
        OP_REMOVE: begin
          cmd.kind  = CMD_DELETE;
          cmd.idx_a = CMD_IDX_W'(req_q.position);
          count_nx  = count_q - CNT_W'(1);
          dout_nx   = word_a_q;
        end
        OP_SWAP: begin
          cmd.kind   = CMD_SWAP;
          cmd.idx_a  = CMD_IDX_W'(req_q.position);
          cmd.idx_b  = CMD_IDX_W'(req_q.other_position);
          cmd.data_a = word_b_q;
          cmd.data_b = word_a_q;
        end
        OP_TRUNCATE: count_nx = CNT_W'(req_q.position);
        default: count_nx = count_q;
      endcase
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cap_q   <= CNT_W'(DEPTH);
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        count_q <= '0;
        if (pwdata == '0) cap_q <= CNT_W'(1);
        else if (pwdata > PDATA_W'(DEPTH)) cap_q <= CNT_W'(DEPTH);
        else cap_q <= CNT_W'(pwdata);
      end else if (state_q == S_COMMIT) begin
        count_q <= count_nx;
      end
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= in_data_i;
      stat_q   <= dec_status;
      rd_idx_q <= dec_rd;
      wait_q   <= WAIT_W'(LEVELS);
    end else if (state_q == S_READ_A && wait_q == '0) begin
      word_a_q <= root;
      rd_idx_q <= IDX_W'(req_q.other_position);
      wait_q   <= WAIT_W'(LEVELS);
    end else if (state_q == S_READ_B && wait_q == '0) begin
      word_b_q <= root;
    end else if (state_q == S_READ_A || state_q == S_READ_B) begin
      wait_q <= wait_q - WAIT_W'(1);
    end
    if (state_q == S_COMMIT) begin
      out_q.data_out <= dout_nx;
      out_q.status   <= stat_q;
      out_q.count    <= CNT_OUT_W'(count_nx);
    end
  end

  // ---------------- cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_w = cell_q[k];
    end else begin : g_mid_hi
      assign next_w = cell_q[k+1];
    end
    cdq_cell #(
      .INDEX (k),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .rd_idx_i (rd_idx_q),
      .data_o   (cell_q[k]),
      .tap_o    (tap[k])
    );
  end

  cdq_tap_tree #(
    .N (DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (tap),
    .root_o (root)
  );

endmodule

[src/cdq_cell.sv]
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 6
) (
  input  logic              clk_i,
  input  cdq_cmd_t          cmd_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tap_o
);

  localparam logic [CMD_IDX_W-1:0] MY_CMD_IDX = CMD_IDX_W'(INDEX);
  localparam logic [IDX_W-1:0]     MY_RD_IDX  = IDX_W'(INDEX);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      CMD_WRITE: begin
        if (cmd_i.idx_a == MY_CMD_IDX) data_d = cmd_i.data_a;
      end
      CMD_SWAP: begin
        if (cmd_i.idx_a == MY_CMD_IDX) data_d = cmd_i.data_a;
        else if (cmd_i.idx_b == MY_CMD_IDX) data_d = cmd_i.data_b;
      end
      CMD_INSERT: begin
        // entries at and above the gap move up one cell
        if (MY_CMD_IDX > cmd_i.idx_a) data_d = prev_i;
        else if (MY_CMD_IDX == cmd_i.idx_a) data_d = cmd_i.data_a;
      end
      CMD_DELETE: begin
        if (MY_CMD_IDX >= cmd_i.idx_a) data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (rd_idx_i == MY_RD_IDX) ? data_q : '0;

endmodule

[src/cdq_tap_tree.sv]
module cdq_tap_tree
  import cdq_pkg::*;
#(
  parameter int N = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] leaf_i [N],
  output logic [DATA_W-1:0] root_o
);

  localparam int LEVELS = cdq_tree_levels(N);

  logic [DATA_W-1:0] tree_q [LEVELS][N];
  logic [DATA_W-1:0] tree_d [LEVELS][N];

  // each level ORs groups of eight from the level below; taps are zero
  // except at the selected cell, so the root is the selected word
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < N; j++) begin
        tree_d[l][j] = '0;
        for (int k = 0; k < TREE_RADIX; k++) begin
          if (TREE_RADIX * j + k < N) begin
            if (l == 0) tree_d[l][j] = tree_d[l][j] | leaf_i[TREE_RADIX * j + k];
            else        tree_d[l][j] = tree_d[l][j] | tree_q[l-1][TREE_RADIX * j + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tree_q <= tree_d;
  end

  assign root_o = tree_q[LEVELS-1][0];

endmodule

[src/cdq_checker.sv]
module cdq_checker
  import cdq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cdq_out_t out_data_o
);

  // one word in flight: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again right after an accept");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.count == '0 && out_data_o.data_out == '0)
    else $error("empty status with nonzero count or data");

endmodule

bind circular_deque_engine_unit cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
